>>> design/pte_pkg.sv
package pte_pkg;

    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int MAG_IN_W = COORD_W;
    localparam int THICK_W  = 12;
    localparam int COLOR_W  = 8;
    localparam int SQ_W     = 2 * MAG_IN_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int Q_W      = MAG_IN_W + THICK_W;
    localparam int Q2_W     = 2 * Q_W;
    localparam int MAG_W    = THICK_W;
    localparam int ACC_W    = Q2_W + 6;
    localparam int WIDE_W   = COORD_W + 2;
    localparam int NUM_VERT = 6;
    localparam int VCNT_W   = 3;
    localparam logic [VCNT_W-1:0] LAST_VERT = VCNT_W'(NUM_VERT - 1);

    localparam logic OP_TILE = 1'b0;
    localparam logic OP_LINE = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic               op;
        coord_t             x0;
        coord_t             y0;
        coord_t             x1;
        coord_t             y1;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } prim_t;

    typedef struct packed {
        prim_t                   prim;
        logic                    hx_neg;
        logic                    hy_neg;
        logic                    drop;
        logic [SUM_W-1:0]        s;
        logic [Q2_W-1:0]         qx2;
        logic [Q2_W-1:0]         qy2;
        logic [MAG_W-1:0]        mx;
        logic [MAG_W-1:0]        my;
        logic signed [ACC_W-1:0] px;
        logic signed [ACC_W-1:0] py;
        logic signed [ACC_W-1:0] csx;
        logic signed [ACC_W-1:0] csy;
    } srch_t;

    typedef struct packed {
        coord_t [3:0]       cx;
        coord_t [3:0]       cy;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } quad_t;

    function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'((1 << (COORD_W - 1)) - 1);
        lo = -hi - WIDE_W'(1);
        if (v > hi)
            return coord_t'(hi);
        else if (v < lo)
            return coord_t'(lo);
        else
            return coord_t'(v);
    endfunction

    // two triangles: v0,v1,v2 then v0,v2,v3
    function automatic logic [1:0] corner_sel(input logic [VCNT_W-1:0] n);
        case (n)
            3'd0:    return 2'd0;
            3'd1:    return 2'd1;
            3'd2:    return 2'd2;
            3'd3:    return 2'd0;
            3'd4:    return 2'd2;
            3'd5:    return 2'd3;
            default: return 2'd0;
        endcase
    endfunction

endpackage

>>> design/pte_front.sv
module pte_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  pte_pkg::prim_t        in_prim,
    input  logic [pte_pkg::THICK_W-1:0] in_thick,
    output logic                  out_valid,
    output pte_pkg::srch_t        out_data
);
    import pte_pkg::*;

    // stage 1: deltas and magnitudes
    logic                      s1_valid_reg;
    prim_t                     s1_prim_reg;
    logic [THICK_W-1:0]        s1_t_reg;
    logic [MAG_IN_W-1:0]       s1_adx_reg, s1_ady_reg;
    logic                      s1_hxn_reg, s1_hyn_reg, s1_drop_reg;
    // stage 2: products
    logic                      s2_valid_reg;
    prim_t                     s2_prim_reg;
    logic                      s2_hxn_reg, s2_hyn_reg, s2_drop_reg;
    logic [SQ_W-1:0]           s2_sqx_reg, s2_sqy_reg;
    logic [Q_W-1:0]            s2_qx_reg, s2_qy_reg;
    // stage 3
    logic                      s3_valid_reg;
    srch_t                     s3_data_reg;

    logic signed [DIFF_W-1:0]  dx, dy, adx_w, ady_w;
    logic [SUM_W-1:0]          s_sum;
    srch_t                     s3_next;

    always_comb
    begin
        dx    = DIFF_W'(in_prim.x1) - DIFF_W'(in_prim.x0);
        dy    = DIFF_W'(in_prim.y1) - DIFF_W'(in_prim.y0);
        adx_w = (dx < 0) ? -dx : dx;
        ady_w = (dy < 0) ? -dy : dy;
    end

    always_comb
    begin
        s_sum = SUM_W'(s2_sqx_reg) + SUM_W'(s2_sqy_reg);
        s3_next.prim   = s2_prim_reg;
        s3_next.hx_neg = s2_hxn_reg;
        s3_next.hy_neg = s2_hyn_reg;
        s3_next.drop   = s2_drop_reg;
        s3_next.s      = s_sum;
        s3_next.qx2    = Q2_W'(s2_qx_reg) * Q2_W'(s2_qx_reg);
        s3_next.qy2    = Q2_W'(s2_qy_reg) * Q2_W'(s2_qy_reg);
        s3_next.mx     = '0;
        s3_next.my     = '0;
        // search starts at c = -1: c*c*S = S, c*S = -S
        s3_next.px     = signed'(ACC_W'(s_sum));
        s3_next.py     = signed'(ACC_W'(s_sum));
        s3_next.csx    = -signed'(ACC_W'(s_sum));
        s3_next.csy    = -signed'(ACC_W'(s_sum));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prim_reg <= in_prim;
            s1_t_reg    <= in_thick;
            s1_adx_reg  <= adx_w[MAG_IN_W-1:0];
            s1_ady_reg  <= ady_w[MAG_IN_W-1:0];
            s1_hxn_reg  <= (dy > 0);
            s1_hyn_reg  <= (dx < 0);
            s1_drop_reg <= (in_prim.op == OP_LINE) && (dx == 0) && (dy == 0);

            s2_prim_reg <= s1_prim_reg;
            s2_hxn_reg  <= s1_hxn_reg;
            s2_hyn_reg  <= s1_hyn_reg;
            s2_drop_reg <= s1_drop_reg;
            s2_sqx_reg  <= SQ_W'(s1_adx_reg) * SQ_W'(s1_adx_reg);
            s2_sqy_reg  <= SQ_W'(s1_ady_reg) * SQ_W'(s1_ady_reg);
            s2_qx_reg   <= Q_W'(s1_ady_reg) * Q_W'(s1_t_reg);
            s2_qy_reg   <= Q_W'(s1_adx_reg) * Q_W'(s1_t_reg);

            s3_data_reg <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

>>> design/pte_root_step.sv
// One bit of m: largest m with (2m-1)^2 * S <= Q^2, MSB first.
module pte_root_step #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  pte_pkg::srch_t in_data,
    output logic           out_valid,
    output pte_pkg::srch_t out_data
);
    import pte_pkg::*;

    logic                    valid_reg;
    srch_t                   data_reg;
    srch_t                   data_next;
    logic signed [ACC_W-1:0] s_ext, sq_term, cand_x, cand_y;

    always_comb
    begin
        s_ext   = signed'(ACC_W'(in_data.s));
        sq_term = s_ext <<< (2 * STEP + 2);
        // (c + 2^(k+1))^2 S = c^2 S + 2^(k+2) cS + 2^(2k+2) S
        cand_x  = in_data.px + (in_data.csx <<< (STEP + 2)) + sq_term;
        cand_y  = in_data.py + (in_data.csy <<< (STEP + 2)) + sq_term;
        data_next = in_data;
        if (cand_x <= signed'(ACC_W'(in_data.qx2)))
        begin
            data_next.mx[STEP] = 1'b1;
            data_next.px       = cand_x;
            data_next.csx      = in_data.csx + (s_ext <<< (STEP + 1));
        end
        if (cand_y <= signed'(ACC_W'(in_data.qy2)))
        begin
            data_next.my[STEP] = 1'b1;
            data_next.py       = cand_y;
            data_next.csy      = in_data.csy + (s_ext <<< (STEP + 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> design/pte_corner.sv
module pte_corner (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  pte_pkg::srch_t in_data,
    output logic           out_valid,
    output logic           out_drop,
    output pte_pkg::quad_t out_quad
);
    import pte_pkg::*;

    logic                     valid_reg, drop_reg;
    quad_t                    quad_reg;
    quad_t                    quad_next;
    logic signed [WIDE_W-1:0] x0, y0, x1, y1, hx, hy, mxw, myw;

    always_comb
    begin
        x0  = WIDE_W'(in_data.prim.x0);
        y0  = WIDE_W'(in_data.prim.y0);
        x1  = WIDE_W'(in_data.prim.x1);
        y1  = WIDE_W'(in_data.prim.y1);
        mxw = signed'(WIDE_W'(in_data.mx));
        myw = signed'(WIDE_W'(in_data.my));
        hx  = in_data.hx_neg ? -mxw : mxw;
        hy  = in_data.hy_neg ? -myw : myw;
        quad_next.r = in_data.prim.r;
        quad_next.g = in_data.prim.g;
        quad_next.b = in_data.prim.b;
        if (in_data.prim.op == OP_TILE)
        begin
            quad_next.cx[0] = sat_coord(x0);
            quad_next.cy[0] = sat_coord(y0);
            quad_next.cx[1] = sat_coord(x0 + x1);
            quad_next.cy[1] = sat_coord(y0);
            quad_next.cx[2] = sat_coord(x0 + x1);
            quad_next.cy[2] = sat_coord(y0 + y1);
            quad_next.cx[3] = sat_coord(x0);
            quad_next.cy[3] = sat_coord(y0 + y1);
        end
        else
        begin
            quad_next.cx[0] = sat_coord(x0 - hx);
            quad_next.cy[0] = sat_coord(y0 - hy);
            quad_next.cx[1] = sat_coord(x0 + hx);
            quad_next.cy[1] = sat_coord(y0 + hy);
            quad_next.cx[2] = sat_coord(x1 + hx);
            quad_next.cy[2] = sat_coord(y1 + hy);
            quad_next.cx[3] = sat_coord(x1 - hx);
            quad_next.cy[3] = sat_coord(y1 - hy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            drop_reg <= in_data.drop;
            quad_reg <= quad_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_drop  = drop_reg;
    assign out_quad  = quad_reg;

endmodule

>>> design/pte_vertex_seq.sv
module pte_vertex_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_drop,
    input  pte_pkg::quad_t              in_quad,
    output logic                        free,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pte_pkg::coord_t             vx,
    output pte_pkg::coord_t             vy,
    output logic [pte_pkg::COLOR_W-1:0] vr,
    output logic [pte_pkg::COLOR_W-1:0] vg,
    output logic [pte_pkg::COLOR_W-1:0] vb,
    output logic                        vlast
);
    import pte_pkg::*;

    logic              busy_reg, busy_next;
    logic [VCNT_W-1:0] cnt_reg, cnt_next;
    quad_t             quad_reg;
    logic              load;
    logic [1:0]        sel;

    assign free = !busy_reg || (!out_stall && cnt_reg == LAST_VERT);
    assign load = in_valid && !in_drop && free;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg && !out_stall)
        begin
            if (cnt_reg == LAST_VERT)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg + VCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            quad_reg <= in_quad;
    end

    assign sel       = corner_sel(cnt_reg);
    assign out_valid = busy_reg;
    assign vx        = quad_reg.cx[sel];
    assign vy        = quad_reg.cy[sel];
    assign vr        = quad_reg.r;
    assign vg        = quad_reg.g;
    assign vb        = quad_reg.b;
    assign vlast     = (cnt_reg == LAST_VERT);

endmodule

>>> design/primitive_to_triangle_expander.sv
// Channel  | Valid      | Stall      | Payload
// ---------+------------+------------+----------------------------------------------
// input    | in_valid   | in_stall   | op, first_x/y, second_x/y, thickness, color_*
// output   | out_valid  | out_stall  | vertex_x/y, out_red/green/blue, last_vertex
//
// From input transaction to first vertex: 3 front stages, 12 offset-search
// stages, 1 corner stage. Each primitive yields 6 vertices, one per cycle
// while out_stall is low; the sequencer takes the next primitive as its last
// vertex leaves. Zero-length lines are dropped with no output. The pipeline
// advances as a whole; it halts while the corner stage holds a primitive the
// busy sequencer cannot take. Reset clears all valid bits and the sequencer.
module primitive_to_triangle_expander (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic signed [15:0]           first_x,
    input  logic signed [15:0]           first_y,
    input  logic signed [15:0]           second_x,
    input  logic signed [15:0]           second_y,
    input  logic [pte_pkg::THICK_W-1:0]  thickness,
    input  logic [pte_pkg::COLOR_W-1:0]  color_red,
    input  logic [pte_pkg::COLOR_W-1:0]  color_green,
    input  logic [pte_pkg::COLOR_W-1:0]  color_blue,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [15:0]           vertex_x,
    output logic signed [15:0]           vertex_y,
    output logic [pte_pkg::COLOR_W-1:0]  out_red,
    output logic [pte_pkg::COLOR_W-1:0]  out_green,
    output logic [pte_pkg::COLOR_W-1:0]  out_blue,
    output logic                         last_vertex
);
    import pte_pkg::*;

    localparam int NSTEP = MAG_W;

    prim_t  prim;
    logic   adv;
    logic   vchain [NSTEP+1];
    srch_t  dchain [NSTEP+1];
    logic   cr_valid, cr_drop, seq_free;
    quad_t  cr_quad;
    coord_t vx, vy;

    always_comb
    begin
        prim.op = op;
        prim.x0 = first_x;
        prim.y0 = first_y;
        prim.x1 = second_x;
        prim.y1 = second_y;
        prim.r  = color_red;
        prim.g  = color_green;
        prim.b  = color_blue;
    end

    assign adv      = !cr_valid || cr_drop || seq_free;
    assign in_stall = !adv;

    pte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .in_prim  (prim),
        .in_thick (thickness),
        .out_valid(vchain[0]),
        .out_data (dchain[0])
    );

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        pte_root_step #(.STEP(NSTEP - 1 - i)) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_valid (vchain[i]),
            .in_data  (dchain[i]),
            .out_valid(vchain[i+1]),
            .out_data (dchain[i+1])
        );
    end

    pte_corner u_corner (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (vchain[NSTEP]),
        .in_data  (dchain[NSTEP]),
        .out_valid(cr_valid),
        .out_drop (cr_drop),
        .out_quad (cr_quad)
    );

    pte_vertex_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cr_valid),
        .in_drop  (cr_drop),
        .in_quad  (cr_quad),
        .free     (seq_free),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .vx       (vx),
        .vy       (vy),
        .vr       (out_red),
        .vg       (out_green),
        .vb       (out_blue),
        .vlast    (last_vertex)
    );

    assign vertex_x = vx;
    assign vertex_y = vy;

endmodule
